>>> sv/rse_pkg.sv
// Package: GF(2^8) arithmetic and generator polynomial for the RS encoder.
`timescale 1ns / 1ps
package rse_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 6;
    localparam int MAX_TERMS = 65;
    localparam logic [8:0] FIELD_POLY = 9'h11D;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IDX_W-1:0]  idx_t;

    function automatic byte_t gf_mul(byte_t a, byte_t b);
        logic [8:0] x;
        byte_t      r;
        x = {1'b0, a};
        r = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                r = r ^ x[7:0];
            end
            x = x << 1;
            if (x[8]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return r;
    endfunction

    // coefficient k of prod (x - alpha^i), i = 1 .. terms-1
    function automatic byte_t gen_coef(int terms, int k);
        byte_t g [0:MAX_TERMS-1];
        byte_t root;
        for (int j = 0; j < MAX_TERMS; j++) begin
            g[j] = '0;
        end
        g[0] = 8'd1;
        root = 8'd1;
        for (int i = 1; i < terms; i++) begin
            root = gf_mul(root, 8'd2);
            for (int j = i; j > 0; j--) begin
                g[j] = g[j-1] ^ gf_mul(g[j], root);
            end
            g[0] = gf_mul(g[0], root);
        end
        return g[k];
    endfunction

endpackage

>>> sv/rse_lfsr.sv
// Parity LFSR, message shift line and byte counter of the RS encoder.
`timescale 1ns / 1ps
module rse_lfsr #(
    parameter int MESSAGE_BYTES   = 16,
    parameter int GENERATOR_TERMS = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  rse_pkg::byte_t   in_byte,
    output logic             last,
    output rse_pkg::byte_t   parity_next [GENERATOR_TERMS-1],
    output rse_pkg::byte_t   msg_next    [MESSAGE_BYTES]
);
    import rse_pkg::*;

    localparam int PARITY = GENERATOR_TERMS - 1;
    localparam int MCW = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;

    byte_t          parity_reg [PARITY];
    byte_t          msg_reg    [MESSAGE_BYTES];
    logic [MCW-1:0] count_reg;
    byte_t          fb;

    assign last = (count_reg == MCW'(MESSAGE_BYTES - 1));
    assign fb   = in_byte ^ parity_reg[PARITY-1];

    assign parity_next[0] = gf_mul(fb, gen_coef(GENERATOR_TERMS, 0));
    for (genvar k = 1; k < PARITY; k++) begin : g_par
        localparam byte_t GK = gen_coef(GENERATOR_TERMS, k);
        assign parity_next[k] = parity_reg[k-1] ^ gf_mul(fb, GK);
    end

    assign msg_next[0] = in_byte;
    for (genvar k = 1; k < MESSAGE_BYTES; k++) begin : g_msg
        assign msg_next[k] = msg_reg[k-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int k = 0; k < PARITY; k++) begin
                parity_reg[k] <= '0;
            end
        end else if (in_fire) begin
            if (last) begin
                count_reg <= '0;
                for (int k = 0; k < PARITY; k++) begin
                    parity_reg[k] <= '0;
                end
            end else begin
                count_reg <= count_reg + MCW'(1);
                for (int k = 0; k < PARITY; k++) begin
                    parity_reg[k] <= parity_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int k = 0; k < MESSAGE_BYTES; k++) begin
                msg_reg[k] <= msg_next[k];
            end
        end
    end

endmodule

>>> sv/rse_drain.sv
// Codeword burst buffer: loads a finished codeword and shifts it out one byte per item.
`timescale 1ns / 1ps
module rse_drain #(
    parameter int MESSAGE_BYTES   = 16,
    parameter int CODEWORD_BYTES  = 46,
    parameter int GENERATOR_TERMS = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  rse_pkg::byte_t   parity_next [GENERATOR_TERMS-1],
    input  rse_pkg::byte_t   msg_next    [MESSAGE_BYTES],
    input  logic             m_ready,
    output logic             m_valid,
    output rse_pkg::byte_t   m_code_byte,
    output rse_pkg::idx_t    m_code_index,
    output logic             m_word_done
);
    import rse_pkg::*;

    localparam int PARITY = GENERATOR_TERMS - 1;
    localparam int DCW = $clog2(CODEWORD_BYTES);

    byte_t                  buf_reg  [CODEWORD_BYTES];
    byte_t                  load_val [CODEWORD_BYTES];
    logic [DCW-1:0]         cnt_reg;
    logic                   valid_reg;
    logic [DCW+IDX_W-1:0]   idx_ext;
    logic                   take;

    for (genvar k = 0; k < CODEWORD_BYTES; k++) begin : g_ld
        if (k < PARITY) begin : g_p
            assign load_val[k] = parity_next[k];
        end else if (k < PARITY + MESSAGE_BYTES) begin : g_m
            assign load_val[k] = msg_next[k-PARITY];
        end else begin : g_z
            assign load_val[k] = '0;
        end
    end

    assign take         = valid_reg && m_ready;
    assign m_valid      = valid_reg;
    assign m_code_byte  = buf_reg[0];
    assign m_word_done  = (cnt_reg == DCW'(CODEWORD_BYTES - 1));
    assign idx_ext      = {{IDX_W{1'b0}}, cnt_reg};
    assign m_code_index = idx_ext[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end else if (take) begin
            if (m_word_done) begin
                valid_reg <= 1'b0;
                cnt_reg   <= '0;
            end else begin
                cnt_reg <= cnt_reg + DCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < CODEWORD_BYTES; k++) begin
                buf_reg[k] <= load_val[k];
            end
        end else if (take) begin
            for (int k = 0; k < CODEWORD_BYTES - 1; k++) begin
                buf_reg[k] <= buf_reg[k+1];
            end
        end
    end

endmodule

>>> sv/reed_solomon_systematic_encoder_unit.sv
// Top level of the systematic RS(46,16) encoder over GF(2^8).
`timescale 1ns / 1ps
// Message bytes are taken one per cycle while s_ready is high, highest
// index first, and each one steps the 30-byte parity LFSR in the same cycle.
// When the last byte of a message is taken, the whole codeword (parity
// bytes 0..29, then message bytes 0..15) is loaded into a burst buffer and
// shown on the m_ side one byte per cycle while m_ready is high, starting the
// next cycle, with m_word_done on the final byte. The next message is
// accepted while the burst drains; only its last byte waits until the
// previous burst has been taken. Sustained throughput is therefore set by
// the single-byte output port of the burst buffer.
module reed_solomon_systematic_encoder_unit #(
    parameter int MESSAGE_BYTES   = 16,
    parameter int CODEWORD_BYTES  = 46,
    parameter int GENERATOR_TERMS = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rse_pkg::byte_t      s_message_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output rse_pkg::byte_t      m_code_byte,
    output rse_pkg::idx_t       m_code_index,
    output logic                m_word_done
);
    import rse_pkg::*;

    byte_t parity_next [GENERATOR_TERMS-1];
    byte_t msg_next    [MESSAGE_BYTES];
    logic  last;
    logic  in_fire;
    logic  can_load;
    logic  load;

    assign can_load = !m_valid || (m_ready && m_word_done);
    assign s_ready  = !last || can_load;
    assign in_fire  = s_valid && s_ready;
    assign load     = in_fire && last;

    rse_lfsr #(
        .MESSAGE_BYTES  (MESSAGE_BYTES),
        .GENERATOR_TERMS(GENERATOR_TERMS)
    ) u_lfsr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_byte    (s_message_byte),
        .last       (last),
        .parity_next(parity_next),
        .msg_next   (msg_next)
    );

    rse_drain #(
        .MESSAGE_BYTES  (MESSAGE_BYTES),
        .CODEWORD_BYTES (CODEWORD_BYTES),
        .GENERATOR_TERMS(GENERATOR_TERMS)
    ) u_drain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .parity_next (parity_next),
        .msg_next    (msg_next),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_code_byte (m_code_byte),
        .m_code_index(m_code_index),
        .m_word_done (m_word_done)
    );

endmodule

>>> sv/rse_checker.sv
// Port-level checks for the RS encoder, bound to the top level.
`timescale 1ns / 1ps
module rse_checker #(
    parameter int CODEWORD_BYTES = 46
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input rse_pkg::byte_t      m_code_byte,
    input rse_pkg::idx_t       m_code_index,
    input logic                m_word_done
);
    import rse_pkg::*;

    localparam idx_t LAST_IDX = IDX_W'((CODEWORD_BYTES - 1) % 64);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_done_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word_done |-> m_code_index == LAST_IDX)
        else $error("word_done on wrong codeword position");

    a_burst_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_word_done |=>
            m_valid && m_code_index == idx_t'($past(m_code_index) + 1'b1))
        else $error("codeword burst broken or out of order");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=>
            m_valid && $stable(m_code_byte) && $stable(m_code_index) && $stable(m_word_done))
        else $error("stalled result item changed");

endmodule

bind reed_solomon_systematic_encoder_unit rse_checker #(
    .CODEWORD_BYTES(CODEWORD_BYTES)
) u_rse_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_code_byte (m_code_byte),
    .m_code_index(m_code_index),
    .m_word_done (m_word_done)
);
